// ----- rtl/fac_pkg.sv -----
// Shared types and constants of the frustum box cull block.
package fac_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned OPND_W = WORD_W + 1;
    localparam int unsigned PROD_W = 2 * OPND_W;
    localparam int unsigned ACC_W  = 72;
    localparam int unsigned PIDX_IN_W = 3;

    localparam logic [WORD_W-1:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] Q_MIN = 32'h8000_0000;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef struct packed {
        logic                        op;
        logic [PIDX_IN_W-1:0]        plane_index;
        logic signed [WORD_W-1:0]    vec_a_x;
        logic signed [WORD_W-1:0]    vec_a_y;
        logic signed [WORD_W-1:0]    vec_a_z;
        logic signed [WORD_W-1:0]    vec_b_x;
        logic signed [WORD_W-1:0]    vec_b_y;
        logic signed [WORD_W-1:0]    vec_b_z;
        logic signed [WORD_W-1:0]    height_scale;
    } t_req;

    typedef struct packed {
        logic visible;
    } t_rsp;

    typedef enum logic [1:0] {
        MK_DOT = 2'd0,
        MK_CY  = 2'd1,
        MK_EY  = 2'd2
    } t_mac_kind;

    typedef struct packed {
        logic      valid;
        t_mac_kind kind;
        logic      plane_end;
    } t_mac_op;

    typedef struct packed {
        logic busy;
        logic visible;
    } t_mac_stat;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCALE = 4'b0010,
        S_DOT   = 4'b0100,
        S_WAIT  = 4'b1000
    } t_state;

endpackage

// ----- rtl/fac_stream_if.sv -----
// Request and response stream interfaces of the frustum box cull block.
interface fac_req_if import fac_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

interface fac_rsp_if import fac_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

// ----- rtl/frustum_aabb_cull_unit.sv -----
// Top level of the frustum box cull block: plane store and sequencer.
// A load request gives no response.
// A test request runs through the scale, dot and wait states before its response.
// A new request is accepted only once the sequencer is idle again, so one test
// must finish before the next is taken; all steps share the single 33x33 multiplier.
// Reset clears the plane valid bits, so unloaded planes read as zero.
module frustum_aabb_cull_unit import fac_pkg::*; #(
    parameter int unsigned NUM_PLANES = 6,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fac_req_if.sink     i_req,
    fac_rsp_if.source   o_rsp
);

    localparam int unsigned PIDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam logic [PIDX_W-1:0] LAST_PLANE = PIDX_W'(NUM_PLANES - 1);

    logic [WORD_W-1:0] r_nrm [NUM_PLANES][3];
    logic [WORD_W-1:0] r_org [NUM_PLANES][3];
    logic [NUM_PLANES-1:0] r_pvld;

    t_state            r_state, n_state;
    logic              r_sel;
    logic [PIDX_W-1:0] r_plane;
    logic [1:0]        r_comp;
    logic              r_half;

    logic [WORD_W-1:0] r_cx, r_cz, r_ex, r_ez, r_cy_raw, r_ey_raw, r_s;
    logic              r_out_valid;
    logic              r_out_vis;

    logic              w_accept;
    logic              w_load_ok;
    logic              w_start;
    logic              w_fire;
    t_mac_op           w_op;
    logic signed [OPND_W-1:0] w_a, w_b;
    logic [WORD_W-1:0] w_cy, w_ey;
    t_mac_stat         w_stat;
    logic [WORD_W-1:0] w_n, w_o, w_c, w_e;
    logic signed [OPND_W-1:0] w_nx, w_an;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_load_ok   = ({1'b0, i_req.payload.plane_index} < (PIDX_IN_W + 1)'(NUM_PLANES));
    assign w_start     = w_accept && (i_req.payload.op == OP_TEST);
    assign w_fire      = (r_state == S_WAIT) && !w_stat.busy && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (w_accept && i_req.payload.op == OP_LOAD && w_load_ok) begin
            r_nrm[i_req.payload.plane_index[PIDX_W-1:0]][0] <= i_req.payload.vec_a_x;
            r_nrm[i_req.payload.plane_index[PIDX_W-1:0]][1] <= i_req.payload.vec_a_y;
            r_nrm[i_req.payload.plane_index[PIDX_W-1:0]][2] <= i_req.payload.vec_a_z;
            r_org[i_req.payload.plane_index[PIDX_W-1:0]][0] <= i_req.payload.vec_b_x;
            r_org[i_req.payload.plane_index[PIDX_W-1:0]][1] <= i_req.payload.vec_b_y;
            r_org[i_req.payload.plane_index[PIDX_W-1:0]][2] <= i_req.payload.vec_b_z;
        end
        if (w_start) begin
            r_cx     <= i_req.payload.vec_a_x;
            r_cy_raw <= i_req.payload.vec_a_y;
            r_cz     <= i_req.payload.vec_a_z;
            r_ex     <= i_req.payload.vec_b_x;
            r_ey_raw <= i_req.payload.vec_b_y;
            r_ez     <= i_req.payload.vec_b_z;
            r_s      <= i_req.payload.height_scale;
        end
        if (w_fire) begin
            r_out_vis <= w_stat.visible;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_start) n_state = S_SCALE;
            S_SCALE: if (r_sel) n_state = S_DOT;
            S_DOT: begin
                if (r_half && r_comp == 2'd2 && r_plane == LAST_PLANE) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT:  if (w_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pvld      <= '0;
            r_sel       <= 1'b0;
            r_plane     <= '0;
            r_comp      <= '0;
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && i_req.payload.op == OP_LOAD && w_load_ok) begin
                r_pvld[i_req.payload.plane_index[PIDX_W-1:0]] <= 1'b1;
            end
            if (w_start) begin
                r_sel   <= 1'b0;
                r_plane <= '0;
                r_comp  <= '0;
                r_half  <= 1'b0;
            end else if (r_state == S_SCALE) begin
                r_sel <= 1'b1;
            end else if (r_state == S_DOT) begin
                r_half <= !r_half;
                if (r_half) begin
                    if (r_comp == 2'd2) begin
                        r_comp  <= '0;
                        r_plane <= r_plane + PIDX_W'(1);
                    end else begin
                        r_comp <= r_comp + 2'd1;
                    end
                end
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        w_n = r_pvld[r_plane] ? r_nrm[r_plane][r_comp] : '0;
        w_o = r_pvld[r_plane] ? r_org[r_plane][r_comp] : '0;
        case (r_comp)
            2'd0: begin
                w_c = r_cx;
                w_e = r_ex;
            end
            2'd1: begin
                w_c = w_cy;
                w_e = w_ey;
            end
            default: begin
                w_c = r_cz;
                w_e = r_ez;
            end
        endcase
        w_nx = {w_n[WORD_W-1], w_n};
        w_an = w_nx[OPND_W-1] ? -w_nx : w_nx;
    end

    always_comb begin
        w_op.valid     = 1'b0;
        w_op.kind      = MK_DOT;
        w_op.plane_end = 1'b0;
        w_a            = '0;
        w_b            = '0;
        case (r_state)
            S_SCALE: begin
                w_op.valid = 1'b1;
                w_op.kind  = r_sel ? MK_EY : MK_CY;
                w_a = r_sel ? {r_ey_raw[WORD_W-1], r_ey_raw} : {r_cy_raw[WORD_W-1], r_cy_raw};
                w_b = {r_s[WORD_W-1], r_s};
            end
            S_DOT: begin
                w_op.valid     = 1'b1;
                w_op.plane_end = r_half && (r_comp == 2'd2);
                if (r_half) begin
                    w_a = w_nx;
                    w_b = {w_c[WORD_W-1], w_c} - {w_o[WORD_W-1], w_o};
                end else begin
                    w_a = w_an;
                    w_b = {w_e[WORD_W-1], w_e};
                end
            end
            default: w_op.valid = 1'b0;
        endcase
    end

    fac_mac #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_op    (w_op),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_cy    (w_cy),
        .o_ey    (w_ey),
        .o_stat  (w_stat)
    );

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.payload.visible = r_out_vis;

endmodule

// ----- rtl/fac_mac.sv -----
// Shared multiplier with the scale, accumulate and plane compare stage.
module fac_mac import fac_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  t_mac_op                  i_op,
    input  logic signed [OPND_W-1:0] i_a,
    input  logic signed [OPND_W-1:0] i_b,
    output logic [WORD_W-1:0]        o_cy,
    output logic [WORD_W-1:0]        o_ey,
    output t_mac_stat                o_stat
);

    logic                     r_p_valid;
    t_mac_op                  r_tag;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_vis;
    logic [WORD_W-1:0]        r_cy;
    logic [WORD_W-1:0]        r_ey;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_shift;
    logic [WORD_W-1:0]        w_sat;
    logic signed [ACC_W-1:0]  w_sum;

    assign w_prod  = PROD_W'(i_a) * PROD_W'(i_b);
    assign w_shift = r_prod >>> FRAC_BITS;
    assign w_sum   = r_acc + ACC_W'(r_prod);

    always_comb begin
        if ((&w_shift[PROD_W-1:WORD_W-1]) || !(|w_shift[PROD_W-1:WORD_W-1])) begin
            w_sat = w_shift[WORD_W-1:0];
        end else if (w_shift[PROD_W-1]) begin
            w_sat = Q_MIN;
        end else begin
            w_sat = Q_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_tag  <= i_op;
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_acc     <= '0;
            r_vis     <= 1'b1;
        end else begin
            r_p_valid <= i_op.valid;
            if (i_start) begin
                r_acc <= '0;
                r_vis <= 1'b1;
            end else if (r_p_valid) begin
                case (r_tag.kind)
                    MK_CY: r_cy <= w_sat;
                    MK_EY: r_ey <= w_sat;
                    MK_DOT: begin
                        if (r_tag.plane_end) begin
                            r_acc <= '0;
                            if (w_sum[ACC_W-1]) begin
                                r_vis <= 1'b0;
                            end
                        end else begin
                            r_acc <= w_sum;
                        end
                    end
                    default: r_acc <= r_acc;
                endcase
            end
        end
    end

    assign o_cy           = r_cy;
    assign o_ey           = r_ey;
    assign o_stat.busy    = r_p_valid;
    assign o_stat.visible = r_vis;

`ifndef SYNTH
    a_prod_follows_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op.valid |=> r_p_valid)
        else $error("product stage did not capture an issued operation");
    a_acc_cleared_at_plane_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_valid && !i_start && r_tag.kind == MK_DOT && r_tag.plane_end) |=> (r_acc == '0))
        else $error("accumulator not cleared after the last term of a plane");
    a_start_sets_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (o_stat.visible && r_acc == '0))
        else $error("test start did not initialize the accumulator and flag");
`endif

endmodule
